### hw/rtl/asbcm_pkg.sv
// ============================================================================
// asbcm_pkg: shared types and constants
// Widths, codes, state encoding and helpers for the box collision mover.
// ============================================================================
package asbcm_pkg;

	// collider table depth and derived index widths
	localparam int MAX_COLLIDERS = 16;
	localparam int IDX_W = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
	localparam int CNT_W = $clog2(MAX_COLLIDERS + 1);

	// fixed field widths
	localparam int POS_W     = 24;
	localparam int VEL_W     = 17;
	localparam int SIZE_W    = 23;
	localparam int SLOT_W    = 4;
	localparam int ACT_W     = 2;
	localparam int CFG_IDX_W = 2;
	// edges: position + offset + size, no wrap
	localparam int EDGE_W    = POS_W + 3;

	// stream word widths
	localparam int IN_DATA_W  = 184;
	localparam int OUT_DATA_W = 56;

	typedef enum logic [ACT_W-1:0] {
		ACT_MOVE  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_PLACE = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFF_X  = 2'd0,
		CFG_OFF_Y  = 2'd1,
		CFG_WIDTH  = 2'd2,
		CFG_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_BOX,
		ST_SCAN,
		ST_RESOLVE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] left;
		logic signed [POS_W-1:0] top;
		logic [SIZE_W-1:0]       width;
		logic [SIZE_W-1:0]       height;
	} coll_t;

	typedef struct packed {
		action_t                 action;
		logic [VEL_W-1:0]        vel_x;
		logic [VEL_W-1:0]        vel_y;
		logic [SLOT_W-1:0]       slot;
		logic signed [POS_W-1:0] rect_left;
		logic signed [POS_W-1:0] rect_top;
		logic [SIZE_W-1:0]       rect_width;
		logic [SIZE_W-1:0]       rect_height;
		logic                    rect_enable;
		logic signed [POS_W-1:0] place_x;
		logic signed [POS_W-1:0] place_y;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] cur_x;
		logic signed [POS_W-1:0] cur_y;
		logic                    moved;
		logic                    hit_horizontal;
		logic                    hit_vertical;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // input word taken this cycle
		logic axis_y;    // 0 horizontal pass, 1 vertical pass
		logic prep;      // form saturated candidate coordinate
		logic box;       // form entity box edges
		logic scan_clr;  // reset scan counter and hit flag
		logic scan_run;  // step through collider table
		logic resolve;   // keep or undo the step
		logic out_load;  // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
	} sts_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic [POS_W:0] v);
		logic signed [POS_W-1:0] r;
		if (v[POS_W] != v[POS_W-1]) begin
			r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [EDGE_W-1:0] sext_pos(input logic [POS_W-1:0] v);
		return {{(EDGE_W-POS_W){v[POS_W-1]}}, v};
	endfunction

	function automatic logic signed [EDGE_W-1:0] zext_size(input logic [SIZE_W-1:0] v);
		return {{(EDGE_W-SIZE_W){1'b0}}, v};
	endfunction

endpackage

### hw/rtl/asbcm_ctrl.sv
// ============================================================================
// asbcm_ctrl: sequencing controller
// Walks a move through two axis passes and owns both stream handshakes.
// ============================================================================
module asbcm_ctrl import asbcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ACT_W-1:0] in_action,
	output logic             out_valid,
	input  logic             out_ready,
	output cmd_t             cmd,
	input  sts_t             sts
);

	state_t state_q, state_nx;
	logic   axis_y_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = (action_t'(in_action) == ACT_MOVE) ? ST_PREP : ST_DONE;
				end
			end
			ST_PREP:    state_nx = ST_BOX;
			ST_BOX:     state_nx = ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nx = ST_RESOLVE;
				end
			end
			ST_RESOLVE: state_nx = axis_y_q ? ST_DONE : ST_PREP;
			ST_DONE: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.axis_y = axis_y_q;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_PREP:    cmd.prep = 1'b1;
			ST_BOX: begin
				cmd.box      = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			ST_SCAN:    cmd.scan_run = 1'b1;
			ST_RESOLVE: cmd.resolve = 1'b1;
			ST_DONE:    cmd.out_load = out_free;
			default:    cmd.axis_y = axis_y_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_y_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.accept) begin
				axis_y_q <= 1'b0;
			end else if (cmd.resolve && !axis_y_q) begin
				axis_y_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/asbcm_dp.sv
// ============================================================================
// asbcm_dp: position, collider table and overlap datapath
// Holds config, position and colliders; one collider compared per cycle.
// ============================================================================
module asbcm_dp import asbcm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  item_t                item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [POS_W-1:0]     cfg_data,
	output result_t              res
);

	// config registers
	logic signed [POS_W-1:0] off_x_q, off_y_q;
	logic [SIZE_W-1:0]       box_w_q, box_h_q;

	// entity state
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic [VEL_W-1:0]        vel_x_q, vel_y_q;
	logic                    is_move_q;
	logic                    hit_h_q, hit_v_q;

	// per-pass work registers
	logic signed [POS_W-1:0]  cand_q;
	logic signed [EDGE_W-1:0] el_q, er_q, et_q, eb_q;
	logic                     ent_ok_q;

	// collider table
	coll_t                    coll_mem [MAX_COLLIDERS];
	logic [MAX_COLLIDERS-1:0] act_q;

	// scan
	logic [CNT_W-1:0] cnt_q;
	logic             scan_end;
	logic             rd_vld_s1, rd_act_s1;
	coll_t            rd_coll_s1;
	logic             hit_q;
	logic             overlap;

	result_t res_q;

	logic [IDX_W-1:0]         slot_idx;
	logic                     wr_en;
	logic [POS_W:0]           sum_x, sum_y;
	logic signed [POS_W-1:0]  tx, ty;
	logic signed [EDGE_W-1:0] el_n, et_n;
	logic signed [EDGE_W-1:0] cl, cr, ct, cb;

	assign slot_idx = IDX_W'(item.slot);
	assign wr_en    = cmd.accept && (item.action == ACT_WRITE)
		&& (32'(item.slot) < MAX_COLLIDERS);
	assign scan_end = (cnt_q == CNT_W'(MAX_COLLIDERS));
	assign sts.scan_done = scan_end && !rd_vld_s1;

	// candidate step, 25-bit sums then saturate
	assign sum_x = {pos_x_q[POS_W-1], pos_x_q}
		+ {{(POS_W+1-VEL_W){vel_x_q[VEL_W-1]}}, vel_x_q};
	assign sum_y = {pos_y_q[POS_W-1], pos_y_q}
		+ {{(POS_W+1-VEL_W){vel_y_q[VEL_W-1]}}, vel_y_q};

	// box under test: stepped axis uses the candidate
	assign tx   = cmd.axis_y ? pos_x_q : cand_q;
	assign ty   = cmd.axis_y ? cand_q : pos_y_q;
	assign el_n = sext_pos(tx) + sext_pos(off_x_q);
	assign et_n = sext_pos(ty) + sext_pos(off_y_q);

	// strict overlap against the collider read last cycle
	always_comb begin
		cl = sext_pos(rd_coll_s1.left);
		ct = sext_pos(rd_coll_s1.top);
		cr = cl + zext_size(rd_coll_s1.width);
		cb = ct + zext_size(rd_coll_s1.height);
		overlap = ent_ok_q && (rd_coll_s1.width != '0) && (rd_coll_s1.height != '0)
			&& (el_q < cr) && (cl < er_q) && (et_q < cb) && (ct < eb_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			box_w_q <= SIZE_W'(4096);
			box_h_q <= SIZE_W'(4096);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_OFF_X:  off_x_q <= cfg_data;
				CFG_OFF_Y:  off_y_q <= cfg_data;
				CFG_WIDTH:  box_w_q <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT: box_h_q <= cfg_data[SIZE_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			hit_h_q <= 1'b0;
			hit_v_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				hit_h_q <= 1'b0;
				hit_v_q <= 1'b0;
				if (item.action == ACT_PLACE) begin
					pos_x_q <= item.place_x;
					pos_y_q <= item.place_y;
				end
			end
			if (cmd.resolve) begin
				if (cmd.axis_y) begin
					hit_v_q <= hit_q;
					if (!hit_q) begin
						pos_y_q <= cand_q;
					end
				end else begin
					hit_h_q <= hit_q;
					if (!hit_q) begin
						pos_x_q <= cand_q;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vel_x_q   <= item.vel_x;
			vel_y_q   <= item.vel_y;
			is_move_q <= (item.action == ACT_MOVE);
		end
		if (cmd.prep) begin
			cand_q <= cmd.axis_y ? sat_pos(sum_y) : sat_pos(sum_x);
		end
		if (cmd.box) begin
			el_q     <= el_n;
			er_q     <= el_n + zext_size(box_w_q);
			et_q     <= et_n;
			eb_q     <= et_n + zext_size(box_h_q);
			ent_ok_q <= (box_w_q != '0) && (box_h_q != '0);
		end
		if (cmd.out_load) begin
			res_q.cur_x          <= pos_x_q;
			res_q.cur_y          <= pos_y_q;
			res_q.moved          <= is_move_q && !(hit_h_q && hit_v_q);
			res_q.hit_horizontal <= hit_h_q;
			res_q.hit_vertical   <= hit_v_q;
		end
	end

	// collider memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			coll_mem[slot_idx] <= '{left: item.rect_left, top: item.rect_top,
				width: item.rect_width, height: item.rect_height};
		end
		if (cmd.scan_run && !scan_end) begin
			rd_coll_s1 <= coll_mem[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (wr_en) begin
			act_q[slot_idx] <= item.rect_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_act_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.scan_clr) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_act_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.scan_run) begin
			if (!scan_end) begin
				cnt_q     <= cnt_q + CNT_W'(1);
				rd_vld_s1 <= 1'b1;
				rd_act_s1 <= act_q[cnt_q[IDX_W-1:0]];
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			if (rd_vld_s1 && rd_act_s1 && overlap) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign res = res_q;

endmodule

### hw/rtl/axis_separated_box_collision_move_top.sv
// ============================================================================
// axis_separated_box_collision_move_top: axis-separated box collision mover
// Entity position plus a collider table; moves step x then y, undo on hit.
// ============================================================================
//
//  channel   | dir | handshake              | word
//  ----------+-----+------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid/tready   | move / collider write / place
//  m_axis    | out | m_axis_tvalid/tready   | position and hit flags
//  cfg       | in  | cfg_we (no ready)      | box offset and size registers
//
// Sequence: a move word runs an x pass and then a y pass before the next
// accept. Each axis pass reads the collider table through its single
// registered read port, one slot per cycle, after its prep and box states,
// then drains and resolves. Write, place and unused words skip the passes.
// Reset clears position, active flags and handshakes and sets config to its
// reset values; collider geometry is not cleared. A result waiting on m_axis
// does not block the next input word; the block only holds in its done state
// if the result register is still full when the next result is ready.
//
module axis_separated_box_collision_move_top import asbcm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// vel_x[16:0], vel_y[33:17], slot[37:34], rect_left[61:38],
	// rect_top[85:62], rect_width[108:86], rect_height[131:109],
	// rect_enable[132], place_x[156:133], place_y[180:157], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [ACT_W-1:0]      s_axis_tuser,
	// master side
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// cur_x[23:0], cur_y[47:24], moved[48], hit_horizontal[49],
	// hit_vertical[50], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [POS_W-1:0]      cfg_data
);

	item_t   item;
	result_t res;
	cmd_t    cmd;
	sts_t    sts;

	// unpack input word
	assign item.action      = action_t'(s_axis_tuser);
	assign item.vel_x       = s_axis_tdata[16:0];
	assign item.vel_y       = s_axis_tdata[33:17];
	assign item.slot        = s_axis_tdata[37:34];
	assign item.rect_left   = s_axis_tdata[61:38];
	assign item.rect_top    = s_axis_tdata[85:62];
	assign item.rect_width  = s_axis_tdata[108:86];
	assign item.rect_height = s_axis_tdata[131:109];
	assign item.rect_enable = s_axis_tdata[132];
	assign item.place_x     = s_axis_tdata[156:133];
	assign item.place_y     = s_axis_tdata[180:157];

	asbcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	asbcm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.res      (res)
	);

	// pack result word
	assign m_axis_tdata = {5'b0, res.hit_vertical, res.hit_horizontal, res.moved,
		res.cur_y, res.cur_x};

endmodule

### hw/rtl/asbcm_checker.sv
// ============================================================================
// asbcm_checker: port-level assertions
// Watches the stream ports of the top level; bound in below.
// ============================================================================
module asbcm_checker import asbcm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word dropped or changed while stalled");

	// block is busy the cycle after it takes a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again before previous word was processed");

	// moved is never set together with both hits
	a_moved_vs_hits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[48] && m_axis_tdata[49] && m_axis_tdata[50]))
		else $error("moved flagged with both axis steps undone");

	// without moved the hit flags agree (non-move word or both undone)
	a_not_moved_hits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[49] == m_axis_tdata[50])
		else $error("hit flags inconsistent with moved");

endmodule

bind axis_separated_box_collision_move_top asbcm_checker u_asbcm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### tb/axis_separated_box_collision_move_top_tb.sv
// ============================================================================
// axis_separated_box_collision_move_top_tb: self-checking bench
// Streams move, collider-write, place and unused words into the mover, keeps
// its own model of the entity position and collider table, and checks every
// result word field by field. Box settings change between phases, including
// the extremes; both stream sides idle and stall at random.
// ============================================================================
module axis_separated_box_collision_move_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import asbcm_pkg::*;

	// cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [ACT_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [POS_W-1:0]      cfg_data = '0;

	axis_separated_box_collision_move_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always #5ns clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the block: entity position, collider table, box regs
	// ------------------------------------------------------------------
	logic signed [POS_W-1:0]  ent_x = '0;
	logic signed [POS_W-1:0]  ent_y = '0;
	logic signed [POS_W-1:0]  wall_left [MAX_COLLIDERS];
	logic signed [POS_W-1:0]  wall_top  [MAX_COLLIDERS];
	logic [SIZE_W-1:0]        wall_w    [MAX_COLLIDERS];
	logic [SIZE_W-1:0]        wall_h    [MAX_COLLIDERS];
	bit                       wall_on   [MAX_COLLIDERS];
	// box registers at their reset values
	logic signed [POS_W-1:0]  box_ox = '0;
	logic signed [POS_W-1:0]  box_oy = '0;
	logic [SIZE_W-1:0]        box_w = SIZE_W'(4096);
	logic [SIZE_W-1:0]        box_h = SIZE_W'(4096);

	item_t   cmd_word_q[$];    // words waiting to be sent
	result_t pos_report_q[$];  // expected result words, oldest first
	item_t   cur_word;         // word currently offered on s_axis
	result_t next_report;
	result_t seen;
	result_t want;

	bit hold_send = 1'b0;      // sender holds off (drain test)
	bit no_idle = 1'b0;        // both sides run flat out
	int n_queued = 0;
	int n_in = 0;
	int n_out = 0;
	int n_moves = 0;
	int n_hit_h = 0;
	int n_hit_v = 0;
	int n_bad = 0;
	int idle_cycles = 0;

	// clamp to the signed position range
	function automatic longint sat_coord(input longint v);
		if (v < -longint'(8388608)) return -longint'(8388608);
		if (v > longint'(8388607)) return longint'(8388607);
		return v;
	endfunction

	// strict overlap of the entity box at (px, py) with any active collider;
	// edges are formed at full width, no wrap
	function automatic bit box_blocked(input longint px, input longint py);
		longint el, et, er, eb, cl, ct, cr, cb;
		bit hit;
		int i;
		hit = 1'b0;
		el = px + longint'(box_ox);
		et = py + longint'(box_oy);
		er = el + longint'(box_w);
		eb = et + longint'(box_h);
		for (i = 0; i < MAX_COLLIDERS; i++) begin
			if (wall_on[i]) begin
				cl = longint'(wall_left[i]);
				ct = longint'(wall_top[i]);
				cr = cl + longint'(wall_w[i]);
				cb = ct + longint'(wall_h[i]);
				if (((el > cl) ? el : cl) < ((er < cr) ? er : cr) &&
				    ((et > ct) ? et : ct) < ((eb < cb) ? eb : cb))
					hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// apply one accepted word to the shadow state, return the result word
	function automatic result_t apply_word(input item_t w);
		result_t r;
		longint nx, ny;
		bit hh, hv;
		hh = 1'b0;
		hv = 1'b0;
		case (w.action)
			ACT_MOVE: begin
				// x first, then y from wherever x ended up
				nx = sat_coord(longint'(ent_x) + longint'($signed(w.vel_x)));
				if (box_blocked(nx, longint'(ent_y))) hh = 1'b1;
				else ent_x = POS_W'(nx);
				ny = sat_coord(longint'(ent_y) + longint'($signed(w.vel_y)));
				if (box_blocked(longint'(ent_x), ny)) hv = 1'b1;
				else ent_y = POS_W'(ny);
			end
			ACT_WRITE: begin
				// geometry is stored even when the slot is disabled
				wall_left[w.slot] = w.rect_left;
				wall_top[w.slot]  = w.rect_top;
				wall_w[w.slot]    = w.rect_width;
				wall_h[w.slot]    = w.rect_height;
				wall_on[w.slot]   = w.rect_enable;
			end
			ACT_PLACE: begin
				ent_x = w.place_x;
				ent_y = w.place_y;
			end
			default: ;
		endcase
		r.cur_x          = ent_x;
		r.cur_y          = ent_y;
		r.moved          = (w.action == ACT_MOVE) && !(hh && hv);
		r.hit_horizontal = hh;
		r.hit_vertical   = hv;
		return r;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_word(input item_t w);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[16:0]    = w.vel_x;
		d[33:17]   = w.vel_y;
		d[37:34]   = w.slot;
		d[61:38]   = w.rect_left;
		d[85:62]   = w.rect_top;
		d[108:86]  = w.rect_width;
		d[131:109] = w.rect_height;
		d[132]     = w.rect_enable;
		d[156:133] = w.place_x;
		d[180:157] = w.place_y;
		return d;
	endfunction

	function automatic int span(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// mostly small steps, some zero, some full range
	function automatic int pick_vel();
		int p;
		p = int'($urandom_range(9));
		if (p == 0) return 0;
		if (p == 1) return span(-65536, 65535);
		return span(-1536, 1536);
	endfunction

	// a word with every field random; callers overwrite what matters
	function automatic item_t rand_word();
		item_t w;
		w.action      = action_t'($urandom_range(3));
		w.vel_x       = VEL_W'($urandom);
		w.vel_y       = VEL_W'($urandom);
		w.slot        = SLOT_W'($urandom);
		w.rect_left   = POS_W'($urandom);
		w.rect_top    = POS_W'($urandom);
		w.rect_width  = SIZE_W'($urandom);
		w.rect_height = SIZE_W'($urandom);
		w.rect_enable = 1'($urandom);
		w.place_x     = POS_W'($urandom);
		w.place_y     = POS_W'($urandom);
		return w;
	endfunction

	task automatic push_word(input item_t w);
		cmd_word_q.push_back(w);
		n_queued++;
	endtask

	task automatic push_move(input int vx, input int vy);
		item_t w;
		w = rand_word();
		w.action = ACT_MOVE;
		w.vel_x = VEL_W'(vx);
		w.vel_y = VEL_W'(vy);
		push_word(w);
	endtask

	task automatic push_place(input longint x, input longint y);
		item_t w;
		w = rand_word();
		w.action = ACT_PLACE;
		w.place_x = POS_W'(sat_coord(x));
		w.place_y = POS_W'(sat_coord(y));
		push_word(w);
	endtask

	task automatic push_wall(input int s, input longint l, input longint t,
	                         input int wd, input int ht, input bit en);
		item_t w;
		w = rand_word();
		w.action = ACT_WRITE;
		w.slot = SLOT_W'(s);
		w.rect_left = POS_W'(sat_coord(l));
		w.rect_top = POS_W'(sat_coord(t));
		w.rect_width = SIZE_W'(wd);
		w.rect_height = SIZE_W'(ht);
		w.rect_enable = en;
		push_word(w);
	endtask

	// place the entity, drop a few colliders around its box, then walk it
	task automatic push_scene();
		longint bx, by, cx, cy;
		int nw, nm, k;
		if ($urandom_range(9) == 0) begin
			bx = $urandom_range(1) ? 8388607 - span(0, 20000) : -8388608 + span(0, 20000);
			by = $urandom_range(1) ? 8388607 - span(0, 20000) : -8388608 + span(0, 20000);
		end else begin
			bx = span(-1048576, 1048576);
			by = span(-1048576, 1048576);
		end
		push_place(bx, by);
		cx = sat_coord(bx) + longint'(box_ox);
		cy = sat_coord(by) + longint'(box_oy);
		nw = span(1, 6);
		for (k = 0; k < nw; k++) begin
			if ($urandom_range(19) == 0)
				push_wall(span(0, MAX_COLLIDERS - 1), cx + span(-12288, 12288),
				          cy + span(-12288, 12288), span(0, 8388607),
				          span(0, 8388607), 1'b1);
			else
				push_wall(span(0, MAX_COLLIDERS - 1), cx + span(-12288, 12288),
				          cy + span(-12288, 12288), span(256, 8192), span(256, 8192),
				          $urandom_range(9) != 0);
		end
		nm = span(4, 12);
		for (k = 0; k < nm; k++)
			push_move(pick_vel(), pick_vel());
	endtask

	// random traffic: mostly scenes, some noise, now and then a table wipe
	task automatic fill(input int count);
		int start, pick, s;
		start = n_queued;
		while (n_queued - start < count) begin
			pick = int'($urandom_range(99));
			if (pick < 12) begin
				push_word(rand_word());
			end else if (pick < 15) begin
				for (s = 0; s < MAX_COLLIDERS; s++)
					push_wall(s, span(-8388608, 8388607), span(-8388608, 8388607),
					          span(0, 8388607), span(0, 8388607), 1'b0);
			end else begin
				push_scene();
			end
		end
	endtask

	// block idle: nothing queued, nothing offered, nothing outstanding
	task automatic settle();
		while (cmd_word_q.size() != 0 || s_axis_tvalid || pos_report_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t a, input logic [POS_W-1:0] v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= a;
		cfg_data <= v;
		case (a)
			CFG_OFF_X:  box_ox = v;
			CFG_OFF_Y:  box_oy = v;
			CFG_WIDTH:  box_w = v[SIZE_W-1:0];
			CFG_HEIGHT: box_h = v[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// all four box registers, only with the block idle
	task automatic set_box(input int ox, input int oy, input int wd, input int ht);
		settle();
		write_reg(CFG_OFF_X, POS_W'(ox));
		write_reg(CFG_OFF_Y, POS_W'(oy));
		write_reg(CFG_WIDTH, POS_W'(wd));
		write_reg(CFG_HEIGHT, POS_W'(ht));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] exp_v,
	                           input logic [POS_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
			n_bad++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued words; a word is predicted when it is taken
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				next_report = apply_word(cur_word);
				pos_report_q.push_back(next_report);
				n_in++;
				if (cur_word.action == ACT_MOVE) n_moves++;
				if (next_report.hit_horizontal) n_hit_h++;
				if (next_report.hit_vertical) n_hit_v++;
			end
			// a new word only once the current one is gone; valid is never
			// dropped while a word is still on offer
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_word_q.size() != 0 && !hold_send &&
				    (no_idle || $urandom_range(99) >= 35)) begin
					cur_word = cmd_word_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pack_word(cur_word);
					s_axis_tuser  <= cur_word.action;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure, compare each result word in order
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_out++;
				seen.cur_x          = m_axis_tdata[POS_W-1:0];
				seen.cur_y          = m_axis_tdata[2*POS_W-1:POS_W];
				seen.moved          = m_axis_tdata[2*POS_W];
				seen.hit_horizontal = m_axis_tdata[2*POS_W+1];
				seen.hit_vertical   = m_axis_tdata[2*POS_W+2];
				if (pos_report_q.size() == 0) begin
					$error("result word %h arrived with nothing pending", m_axis_tdata);
					n_bad++;
				end else begin
					want = pos_report_q.pop_front();
					check_field("cur_x", want.cur_x, seen.cur_x);
					check_field("cur_y", want.cur_y, seen.cur_y);
					check_field("moved", POS_W'(want.moved), POS_W'(seen.moved));
					check_field("hit_horizontal", POS_W'(want.hit_horizontal),
					            POS_W'(seen.hit_horizontal));
					check_field("hit_vertical", POS_W'(want.hit_vertical),
					            POS_W'(seen.hit_vertical));
				end
			end
			m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
		end
	end

	// watchdog: any handshake on either side restarts the count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d results outstanding",
			         idle_cycles, pos_report_q.size());
			$display("axis_separated_box_collision_move_top_tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------
	initial begin
		int mark;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words, reset box settings (offset 0, 4096x4096 box)
		push_move(0, 0);                        // zero step, empty table: still moved
		push_move(65535, -65536);               // velocity extremes, nothing to hit
		push_place(8388607, -8388608);
		push_move(65535, -65536);               // both axes saturate
		push_place(-8388608, 8388607);
		push_move(-65536, 65535);               // saturate the other way
		push_place(0, 0);
		push_wall(0, 4096, -2048, 4096, 8192, 1'b1);   // wall to the right
		push_move(256, 0);                      // x blocked, y kept
		push_wall(1, -8192, 4096, 16384, 4096, 1'b1);  // floor below
		push_move(256, 256);                    // both blocked, not moved
		push_move(0, 0);                        // edges touching only: no hit
		push_move(-256, -256);
		push_wall(1, -8192, 4096, 16384, 4096, 1'b0);  // floor disabled
		push_move(0, 512);
		push_wall(2, -4096, -4096, 0, 16384, 1'b1);    // zero-width line
		push_move(-8192, 0);                    // passes through it
		push_wall(15, -8388608, 8388607, 8388607, 8388607, 1'b1);
		push_move(1, 1);
		push_wall(15, 8388607, -8388608, 0, 0, 1'b0);
		push_word(rand_word());
		cur_word = rand_word();
		cur_word.action = ACT_NONE;             // unused action: position only
		push_word(cur_word);
		push_place(-1, -1);
		settle();

		// moderate box, first stretch at full rate
		set_box(span(-4096, 4096), span(-4096, 4096), span(512, 8192), span(512, 8192));
		no_idle = 1'b1;
		mark = n_in;
		fill(320);
		while (n_in < mark + 150 && cmd_word_q.size() != 0) @(negedge clk);
		no_idle = 1'b0;
		settle();

		// extreme offsets with the widest box
		set_box(8388607, -8388608, 8388607, 8388607);
		fill(90);
		settle();

		// opposite extreme offsets, empty box never overlaps
		set_box(-8388608, 8388607, 0, 0);
		fill(90);
		settle();

		// back to the reset values, with a full drain in the middle
		set_box(0, 0, 4096, 4096);
		fill(380);
		while (cmd_word_q.size() > 190) @(negedge clk);
		hold_send = 1'b1;
		while (s_axis_tvalid || pos_report_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		hold_send = 1'b0;
		settle();

		// let any stray output show up before the verdict
		repeat (60) @(negedge clk);
		$display("covered %0d words (%0d moves, %0d x hits, %0d y hits), %0d results checked,",
		         n_in, n_moves, n_hit_h, n_hit_v, n_out);
		$display("under reset, moderate, extreme and zero box settings");
		if (n_bad == 0) begin
			$display("axis_separated_box_collision_move_top_tb: done, clean");
		end else begin
			$display("axis_separated_box_collision_move_top_tb: done, errors");
		end
		$finish;
	end

endmodule

### axis_separated_box_collision_move_top.f
hw/rtl/asbcm_pkg.sv
hw/rtl/asbcm_ctrl.sv
hw/rtl/asbcm_dp.sv
hw/rtl/axis_separated_box_collision_move_top.sv
hw/rtl/asbcm_checker.sv
tb/axis_separated_box_collision_move_top_tb.sv
